@@ sv/cpd_pkg.sv @@
`timescale 1ns / 1ps

package cpd_pkg;

    // One price bar as it enters the block.
    typedef struct packed {
        logic [31:0] open_price;
        logic [31:0] high_price;
        logic [31:0] low_price;
        logic [31:0] close_price;
        logic [31:0] volume;
    } t_bar;

    // One detection result per bar.
    typedef struct packed {
        logic [15:0] pattern_mask;
        logic        strong_engulf;
        logic        evaluated;
    } t_result;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MIN_BARS     = 2'd0,
        CFG_FAST_PERIOD  = 2'd1,
        CFG_SLOW_PERIOD  = 2'd2,
        CFG_VOLUME_RATIO = 2'd3
    } t_cfg_idx;

    // Register values after reset.
    localparam logic [6:0] RST_MIN_BARS     = 7'd1;
    localparam logic [6:0] RST_FAST_PERIOD  = 7'd5;
    localparam logic [6:0] RST_SLOW_PERIOD  = 7'd20;
    localparam logic [7:0] RST_VOLUME_RATIO = 8'd24;

    // Bit positions in the pattern mask.
    localparam int P_DOJI          = 0;
    localparam int P_HAMMER        = 1;
    localparam int P_INV_HAMMER    = 2;
    localparam int P_HANGING_MAN   = 3;
    localparam int P_SHOOTING_STAR = 4;
    localparam int P_BULL_ENGULF   = 5;
    localparam int P_BEAR_ENGULF   = 6;
    localparam int P_MORNING_STAR  = 7;
    localparam int P_EVENING_STAR  = 8;
    localparam int P_THREE_SOLD    = 9;
    localparam int P_THREE_CROWS   = 10;
    localparam int P_GOLDEN_CROSS  = 11;
    localparam int P_DEATH_CROSS   = 12;
    localparam int P_BULL_ALIGN    = 13;
    localparam int P_BEAR_ALIGN    = 14;
    localparam int P_VOL_BREAKOUT  = 15;

endpackage

@@ sv/cpd_stream_if.sv @@
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload of type T per transaction.
interface cpd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/candlestick_pattern_detector_core.sv @@
`timescale 1ns / 1ps

// Candlestick pattern detector. Each bar transaction on i_bar produces exactly one result
// transaction on o_res. Each accepted bar first walks the close ring: the moving-average
// window sums are rebuilt from the ring memory one read per cycle, walking back over
// max(fast, slow effective period) bars, so a period change takes effect on the next bar.
// Four products then go through one shared multiplier, one per cycle, and the patterns
// are decided in the evaluate state once the output register is free. The block takes
// one bar at a time; a finished result waits in the output register while the next bar
// is accepted. Write configuration only while no bar is in flight.
module candlestick_pattern_detector_core #(
    parameter int MAX_PERIOD      = 64,
    parameter int BREAKOUT_WINDOW = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpd_stream_if.sink   i_bar,
    cpd_stream_if.source o_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import cpd_pkg::*;

    localparam int AW   = $clog2(MAX_PERIOD);
    localparam int PW   = $clog2(MAX_PERIOD + 1);
    localparam int KW   = PW + 1;
    localparam int SW   = 32 + $clog2(MAX_PERIOD);
    localparam int BXW  = $clog2(BREAKOUT_WINDOW);
    localparam int JW   = $clog2(BREAKOUT_WINDOW + 1);
    localparam int VSW  = 32 + $clog2(BREAKOUT_WINDOW);
    localparam int MAW  = (SW > VSW) ? SW : VSW;
    localparam int MBW  = (PW > 8) ? PW : 8;
    localparam int PRW  = MAW + MBW;

    typedef logic signed [39:0] t_s40;

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_MUL, S_EVAL} t_state;
    typedef enum logic [1:0] {M_FAST, M_SLOW, M_CLOSE, M_VOL} t_mul_step;
    typedef enum logic [1:0] {ORD_NONE, ORD_BELOW, ORD_EQUAL, ORD_ABOVE} t_order;

    function automatic t_s40 to_s(input logic [31:0] x);
        return t_s40'({8'd0, x});
    endfunction

    // Control and configuration state.
    t_state    r_state;
    t_mul_step r_mstep;
    logic [6:0] r_min_bars, r_fast, r_slow;
    logic [7:0] r_vratio;

    // Bar in flight and history.
    t_bar        r_bar;
    logic [AW-1:0] r_ptr;
    logic [MAX_PERIOD-1:0] r_ring_vld;
    logic [31:0] r_highs [BREAKOUT_WINDOW];
    logic [31:0] r_vols  [BREAKOUT_WINDOW];
    logic [31:0] r_o1, r_o2, r_l1, r_l2, r_c1, r_c2;
    t_order      r_prev_order;
    logic [7:0]  r_cnt;

    // Sum walk and window scan.
    logic [KW-1:0]  r_k;
    logic           r_rd_vld;
    logic [KW-1:0]  r_rd_k;
    logic           r_rd_vbit;
    logic [SW-1:0]  r_fsum, r_ssum;
    logic [JW-1:0]  r_j;
    logic [31:0]    r_ph;
    logic [VSW-1:0] r_vs;

    // Products.
    logic [PRW-1:0] r_fx, r_sx, r_cx, r_vx;

    // Output register.
    logic    r_out_valid;
    t_result r_out;

    // Effective periods and min_bars.
    logic [PW-1:0] fp, sp, maxp;
    logic [7:0]    mb;

    always_comb begin
        if (r_fast == 7'd0) begin
            fp = PW'(1);
        end else if (10'(r_fast) > 10'(MAX_PERIOD)) begin
            fp = PW'(MAX_PERIOD);
        end else begin
            fp = PW'(r_fast);
        end
        if (r_slow == 7'd0) begin
            sp = PW'(1);
        end else if (10'(r_slow) > 10'(MAX_PERIOD)) begin
            sp = PW'(MAX_PERIOD);
        end else begin
            sp = PW'(r_slow);
        end
        maxp = (fp > sp) ? fp : sp;
        mb   = (r_min_bars == 7'd0) ? 8'd1 : {1'b0, r_min_bars};
    end

    // Ring memory access: write at acceptance, read k bars back during the walk.
    logic            bar_acc;
    logic [AW-1:0]   rd_addr;
    logic [PW:0]     wrap_addr;
    logic [31:0]     ram_q;
    logic            issue;

    assign bar_acc   = i_bar.valid && i_bar.ready;
    assign wrap_addr = (PW + 1)'(r_ptr) + (PW + 1)'(MAX_PERIOD) - (PW + 1)'(r_k);
    assign rd_addr   = ((PW + 1)'(r_ptr) >= (PW + 1)'(r_k)) ? AW'(r_ptr - AW'(r_k))
                                                            : AW'(wrap_addr);
    assign issue     = (r_state == S_SUM) && (r_k <= KW'(maxp));

    cpd_ram #(
        .WIDTH (32),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (bar_acc),
        .i_waddr (r_ptr),
        .i_wdata (i_bar.data.close_price),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Shared multiplier operand selection.
    logic [MAW-1:0] mul_a;
    logic [MBW-1:0] mul_b;
    logic [PRW-1:0] mul_p;

    always_comb begin
        unique case (r_mstep)
            M_FAST: begin
                mul_a = MAW'(r_fsum);
                mul_b = MBW'(sp);
            end
            M_SLOW: begin
                mul_a = MAW'(r_ssum);
                mul_b = MBW'(fp);
            end
            M_CLOSE: begin
                mul_a = MAW'(r_bar.close_price);
                mul_b = MBW'(sp);
            end
            default: begin
                mul_a = MAW'(r_vs);
                mul_b = MBW'(r_vratio);
            end
        endcase
        mul_p = PRW'(mul_a) * PRW'(mul_b);
    end

    // Pattern decision from the registered bar, history and products.
    t_s40   o, h, l, c, o1, h1, l1, c1, o2, h2, l2, c2;
    t_s40   rng, body, pbody, p2body, up, lo, maxoc, minoc, r0, r1;
    logic   valid, bull, bear, doji, pbull, pbear, i_gt0, i_ge2, i_gew, mb_ok, ma_ok;
    logic   lo_long, up_long, lo_short, up_short, c_high, c_low, big;
    t_order cur_order;
    logic [15:0] mask;
    logic        strong_hit, evaluated;

    always_comb begin
        o  = to_s(r_bar.open_price);
        h  = to_s(r_bar.high_price);
        l  = to_s(r_bar.low_price);
        c  = to_s(r_bar.close_price);
        o1 = to_s(r_o1);
        h1 = to_s(r_highs[0]);
        l1 = to_s(r_l1);
        c1 = to_s(r_c1);
        o2 = to_s(r_o2);
        h2 = to_s(r_highs[1]);
        l2 = to_s(r_l2);
        c2 = to_s(r_c2);

        valid = (l <= o) && (l <= c) && (h >= o) && (h >= c);
        rng   = h - l;
        bull  = c > o;
        bear  = c < o;
        body  = bull ? (c - o) : (o - c);
        maxoc = bull ? c : o;
        minoc = bull ? o : c;
        doji  = (body * 10) <= rng;
        pbull = c1 > o1;
        pbear = c1 < o1;
        pbody = pbull ? (c1 - o1) : (o1 - c1);
        p2body = (c2 > o2) ? (c2 - o2) : (o2 - c2);
        up    = h - maxoc;
        lo    = minoc - l;
        r0    = h2 - l2;
        r1    = h1 - l1;

        lo_long  = lo >= body * 2;
        up_long  = up >= body * 2;
        lo_short = lo * 20 <= rng * 7;
        up_short = up * 20 <= rng * 7;
        c_high   = (c - l) * 5 >= rng * 3;
        c_low    = (h - c) * 5 >= rng * 3;
        big      = body >= pbody * 2;

        i_gt0 = r_cnt != 8'd0;
        i_ge2 = r_cnt >= 8'd2;
        i_gew = r_cnt >= 8'(BREAKOUT_WINDOW);
        mb_ok = (9'(r_cnt) + 9'd1) >= 9'(mb);
        ma_ok = ((10'(r_cnt) + 10'd1) >= 10'(fp)) && ((10'(r_cnt) + 10'd1) >= 10'(sp));

        // Moving-average order with this bar included.
        if (!ma_ok) begin
            cur_order = ORD_NONE;
        end else if (r_fx < r_sx) begin
            cur_order = ORD_BELOW;
        end else if (r_fx == r_sx) begin
            cur_order = ORD_EQUAL;
        end else begin
            cur_order = ORD_ABOVE;
        end

        mask       = '0;
        strong_hit = 1'b0;
        evaluated  = valid && (rng > 0) && mb_ok;

        if (evaluated) begin
            mask[P_DOJI] = doji;
            if (i_gt0) begin
                // Shadow patterns depend on the prior bar's direction.
                if (!doji && (body > 0)) begin
                    mask[P_HAMMER]        = pbear && lo_long && up_short && c_high;
                    mask[P_INV_HAMMER]    = pbear && up_long && lo_short && c_low;
                    mask[P_HANGING_MAN]   = pbull && lo_long && up_short && c_high;
                    mask[P_SHOOTING_STAR] = pbull && up_long && lo_short && c_low;
                end
                // Engulfing patterns.
                if (pbody > 0) begin
                    if (pbear && bull && (o <= c1) && (c >= o1)) begin
                        mask[P_BULL_ENGULF] = 1'b1;
                        strong_hit = strong_hit || big;
                    end
                    if (pbull && bear && (o >= c1) && (c <= o1)) begin
                        mask[P_BEAR_ENGULF] = 1'b1;
                        strong_hit = strong_hit || big;
                    end
                end
                // Star patterns with a small middle body.
                if (i_ge2 && (p2body > 0) && (pbody * 10 <= p2body * 3)) begin
                    mask[P_MORNING_STAR] = (c2 < o2) && bull && (c1 < c2) && (c * 2 > o2 + c2);
                    mask[P_EVENING_STAR] = (c2 > o2) && bear && (c1 > c2) && (c * 2 < o2 + c2);
                end
            end
            // Three soldiers and three crows.
            if (i_ge2 && (r0 > 0) && (r1 > 0)) begin
                mask[P_THREE_SOLD] = (c2 > o2) && (c1 > o1) && bull && (c1 > c2) && (c > c1)
                    && ((c2 - l2) * 5 >= r0 * 3) && ((c1 - l1) * 5 >= r1 * 3)
                    && ((c - l) * 5 >= rng * 3);
                mask[P_THREE_CROWS] = (c2 < o2) && (c1 < o1) && bear && (c1 < c2) && (c < c1)
                    && ((c2 - l2) * 5 <= r0 * 2) && ((c1 - l1) * 5 <= r1 * 2)
                    && ((c - l) * 5 <= rng * 2);
            end
            // Moving-average crosses and alignments.
            if ((cur_order != ORD_NONE) && (r_prev_order != ORD_NONE) && i_gt0) begin
                mask[P_GOLDEN_CROSS] = ((r_prev_order == ORD_BELOW) ||
                                        (r_prev_order == ORD_EQUAL)) && (cur_order == ORD_ABOVE);
                mask[P_DEATH_CROSS]  = ((r_prev_order == ORD_EQUAL) ||
                                        (r_prev_order == ORD_ABOVE)) && (cur_order == ORD_BELOW);
                mask[P_BULL_ALIGN]   = (cur_order == ORD_ABOVE) && (r_prev_order == ORD_ABOVE)
                                       && (r_cx > PRW'(r_ssum));
                mask[P_BEAR_ALIGN]   = (cur_order == ORD_BELOW) && (r_prev_order == ORD_BELOW)
                                       && (r_cx < PRW'(r_ssum));
            end
            // Volume breakout above the recent highs.
            if (i_gew && bull) begin
                mask[P_VOL_BREAKOUT] = (r_vs != '0) && (r_bar.close_price > r_ph) &&
                    ((PRW'(r_bar.volume) * PRW'(16 * BREAKOUT_WINDOW)) >= r_vx);
            end
        end
    end

    logic eval_go;
    assign eval_go = (r_state == S_EVAL) && (!r_out_valid || o_res.ready);

    // Sequencer, history and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mstep      <= M_FAST;
            r_min_bars   <= RST_MIN_BARS;
            r_fast       <= RST_FAST_PERIOD;
            r_slow       <= RST_SLOW_PERIOD;
            r_vratio     <= RST_VOLUME_RATIO;
            r_ptr        <= '0;
            r_ring_vld   <= '0;
            r_o1         <= '0;
            r_o2         <= '0;
            r_l1         <= '0;
            r_l2         <= '0;
            r_c1         <= '0;
            r_c2         <= '0;
            r_prev_order <= ORD_NONE;
            r_cnt        <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int n = 0; n < BREAKOUT_WINDOW; n++) begin
                r_highs[n] <= '0;
                r_vols[n]  <= '0;
            end
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_BARS:     r_min_bars <= i_cfg_data[6:0];
                    CFG_FAST_PERIOD:  r_fast     <= i_cfg_data[6:0];
                    CFG_SLOW_PERIOD:  r_slow     <= i_cfg_data[6:0];
                    default:          r_vratio   <= i_cfg_data;
                endcase
            end

            // A finished bar fills the output register; a taken result frees it.
            if (eval_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (bar_acc) begin
                        r_bar             <= i_bar.data;
                        r_ring_vld[r_ptr] <= 1'b1;
                        r_ptr    <= (r_ptr == AW'(MAX_PERIOD - 1)) ? '0 : r_ptr + AW'(1);
                        r_k      <= KW'(1);
                        r_rd_vld <= 1'b0;
                        r_fsum   <= '0;
                        r_ssum   <= '0;
                        r_j      <= '0;
                        r_ph     <= '0;
                        r_vs     <= '0;
                        r_state  <= S_SUM;
                    end
                end
                S_SUM: begin
                    // Issue one ring read per cycle, accumulate the one returned.
                    r_rd_vld  <= issue;
                    r_rd_k    <= r_k;
                    r_rd_vbit <= r_ring_vld[rd_addr];
                    if (issue) begin
                        r_k <= r_k + KW'(1);
                    end
                    if (r_rd_vld && r_rd_vbit) begin
                        if (r_rd_k <= KW'(fp)) begin
                            r_fsum <= r_fsum + SW'(ram_q);
                        end
                        if (r_rd_k <= KW'(sp)) begin
                            r_ssum <= r_ssum + SW'(ram_q);
                        end
                    end
                    // Scan of the recent highs and volumes.
                    if (r_j < JW'(BREAKOUT_WINDOW)) begin
                        if (r_highs[r_j[BXW-1:0]] > r_ph) begin
                            r_ph <= r_highs[r_j[BXW-1:0]];
                        end
                        r_vs <= r_vs + VSW'(r_vols[r_j[BXW-1:0]]);
                        r_j  <= r_j + JW'(1);
                    end
                    if (!issue && !r_rd_vld && (r_j == JW'(BREAKOUT_WINDOW))) begin
                        r_mstep <= M_FAST;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    unique case (r_mstep)
                        M_FAST:  r_fx <= mul_p;
                        M_SLOW:  r_sx <= mul_p;
                        M_CLOSE: r_cx <= mul_p;
                        default: r_vx <= mul_p;
                    endcase
                    if (r_mstep == M_VOL) begin
                        r_state <= S_EVAL;
                    end else begin
                        r_mstep <= t_mul_step'(r_mstep + 2'd1);
                    end
                end
                default: begin
                    if (eval_go) begin
                        r_out.pattern_mask  <= mask;
                        r_out.strong_engulf <= strong_hit;
                        r_out.evaluated     <= evaluated;
                        for (int n = BREAKOUT_WINDOW - 1; n > 0; n--) begin
                            r_highs[n] <= r_highs[n-1];
                            r_vols[n]  <= r_vols[n-1];
                        end
                        r_highs[0]   <= r_bar.high_price;
                        r_vols[0]    <= r_bar.volume;
                        r_o2         <= r_o1;
                        r_o1         <= r_bar.open_price;
                        r_l2         <= r_l1;
                        r_l1         <= r_bar.low_price;
                        r_c2         <= r_c1;
                        r_c1         <= r_bar.close_price;
                        r_prev_order <= cur_order;
                        if (r_cnt != 8'd255) begin
                            r_cnt <= r_cnt + 8'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign i_bar.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
endmodule

@@ sv/cpd_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM with one write port and a registered read port.
module cpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/cpd_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks of the detector.
module cpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input cpd_pkg::t_result i_out_data
);
    import cpd_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // One bar at a time: no new bar right after one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("bar accepted while another is in flight");

    // A skipped bar reports nothing.
    a_skip_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.evaluated |->
        (i_out_data.pattern_mask == 16'd0) && !i_out_data.strong_engulf)
        else $error("patterns on an unevaluated bar");

    // Strong engulf comes only with an engulfing pattern.
    a_strong_engulf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.strong_engulf |->
        i_out_data.pattern_mask[P_BULL_ENGULF] || i_out_data.pattern_mask[P_BEAR_ENGULF])
        else $error("strong engulf without engulfing");
endmodule

bind candlestick_pattern_detector_core cpd_checker u_cpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_bar.valid),
    .i_in_ready  (i_bar.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
